### sv/binomial_divisor_count_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binomial divisor count block
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_DIVISOR_COUNT_ASSERT_SVH
`define BINOMIAL_DIVISOR_COUNT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("bdc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("bdc assertion failed");

`endif

### sv/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared widths, job types and the elaboration-time prime list.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

	localparam int unsigned DATA_W        = 9;
	localparam int unsigned COUNT_W       = 64;
	localparam int unsigned EXP_W         = 4;
	localparam int unsigned MAX_N_DEFAULT = 511;
	localparam int unsigned MAX_N_LIMIT   = 4095;
	localparam int unsigned PRIME_W_MAX   = 12;
	localparam int unsigned PRIME_CAP     = 564;
	localparam int unsigned QUEUE_DEPTH   = 2;
	localparam int unsigned LANES         = 3;

	typedef logic [DATA_W-1:0] arg_t;

	typedef struct packed {
		arg_t total_n;
		arg_t chosen_k;
		arg_t rest;
		logic bad;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	typedef struct packed {
		logic avail;
		job_t job;
	} head_t;

	typedef logic [PRIME_W_MAX-1:0] prime_t;
	typedef prime_t [PRIME_CAP-1:0] prime_list_t;

	// Composite marks from a sieve; used at elaboration only.
	function automatic logic [MAX_N_LIMIT:0] sieve(input int unsigned max_n);
		logic [MAX_N_LIMIT:0] comp;
		int unsigned i;
		int unsigned j;
		comp = '0;
		for (i = 2; i * i <= max_n; i++) begin
			if (!comp[i]) begin
				for (j = i * i; j <= max_n; j += i) begin
					comp[j] = 1'b1;
				end
			end
		end
		return comp;
	endfunction

	function automatic int unsigned prime_count(input int unsigned max_n);
		logic [MAX_N_LIMIT:0] comp;
		int unsigned i;
		int unsigned cnt;
		comp = sieve(max_n);
		cnt  = 0;
		for (i = 2; i <= max_n; i++) begin
			if (!comp[i]) begin
				cnt++;
			end
		end
		return cnt;
	endfunction

	function automatic prime_list_t prime_list(input int unsigned max_n);
		logic [MAX_N_LIMIT:0] comp;
		prime_list_t list;
		int unsigned i;
		int unsigned cnt;
		comp = sieve(max_n);
		list = '0;
		cnt  = 0;
		for (i = 2; i <= max_n; i++) begin
			if (!comp[i]) begin
				list[cnt] = prime_t'(i);
				cnt++;
			end
		end
		return list;
	endfunction

endpackage

`default_nettype wire

### sv/bdc_if.sv
// ----------------------------------------------------------------------------
// bdc_req_if / bdc_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdc_req_if;
	logic              valid;
	logic              ready;
	bdc_pkg::arg_t     total_n;
	bdc_pkg::arg_t     chosen_k;

	modport source (output valid, output total_n, output chosen_k, input ready);
	modport sink   (input valid, input total_n, input chosen_k, output ready);
endinterface

interface bdc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bdc_pkg::COUNT_W-1:0]  divisor_count;
	logic                         overflow;
	logic                         bad_input;

	modport source (output valid, output divisor_count, output overflow, output bad_input,
		input ready);
	modport sink   (input valid, input divisor_count, input overflow, input bad_input,
		output ready);
endinterface

`default_nettype wire

### sv/bdc_queue.sv
// ----------------------------------------------------------------------------
// bdc_queue
// Short FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  bdc_pkg::push_t  push,
	input  logic            pop,
	output bdc_pkg::head_t  head,
	output logic            full
);

	localparam int unsigned DEPTH = bdc_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bdc_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head.avail = (cnt_q != '0);
	assign head.job   = mem_q[rd_ptr_q];
	assign do_push    = push.push && !full;
	assign do_pop     = pop && head.avail;

	// advance a pointer, wrapping at the depth
	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		nxt = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
		return nxt;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

endmodule

`default_nettype wire

### sv/bdc_front.sv
// ----------------------------------------------------------------------------
// bdc_front
// Accept request words, flag k > n and precompute n - k.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_front (
	bdc_req_if.sink         req,
	input  logic            full,
	output bdc_pkg::push_t  push
);

	assign req.ready         = !full;
	assign push.push         = req.valid && !full;
	assign push.job.total_n  = req.total_n;
	assign push.job.chosen_k = req.chosen_k;
	assign push.job.bad      = (req.chosen_k > req.total_n);
	// drop the borrow; only meaningful when k <= n
	assign push.job.rest     = req.total_n - req.chosen_k;

endmodule

`default_nettype wire

### sv/bdc_back.sv
// ----------------------------------------------------------------------------
// bdc_back
// Walk the prime list, count carries by repeated division, multiply factors.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_back #(
	parameter int unsigned MAX_N = bdc_pkg::MAX_N_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bdc_pkg::head_t  head,
	output logic            pop,
	bdc_rsp_if.source       rsp
);

	localparam int unsigned DW         = bdc_pkg::DATA_W;
	localparam int unsigned CW         = bdc_pkg::COUNT_W;
	localparam int unsigned EW         = bdc_pkg::EXP_W;
	localparam int unsigned LN         = bdc_pkg::LANES;
	localparam int unsigned WIDE_W     = CW + EW;
	localparam int unsigned NUM_PRIMES = bdc_pkg::prime_count(MAX_N);
	localparam int unsigned PRIME_W    = $clog2(MAX_N + 1);
	localparam int unsigned CMP_W      = (PRIME_W > DW) ? PRIME_W : DW;
	localparam int unsigned IDX_W      = (NUM_PRIMES > 1) ? $clog2(NUM_PRIMES) : 1;
	localparam int unsigned STEP_W     = $clog2(DW);
	localparam bdc_pkg::prime_list_t PRIME_LIST = bdc_pkg::prime_list(MAX_N);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FETCH = 8'b0000_0010,
		S_CHECK = 8'b0000_0100,
		S_LEVEL = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_ACC   = 8'b0010_0000,
		S_MULT  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [STEP_W-1:0]    step_q;
	logic [PRIME_W-1:0]   prime_q;
	logic [DW-1:0]        n_q;
	logic [DW-1:0]        k_q;
	logic [DW-1:0]        rest_q;
	logic                 bad_q;
	logic [DW-1:0]        quo_q [LN];
	logic [DW-1:0]        rem_q [LN];
	logic [EW-1:0]        exp_q;
	logic [CW-1:0]        prod_q;
	logic                 ovf_q;
	logic                 valid_q;
	logic [CW-1:0]        count_out_q;
	logic                 ovf_out_q;
	logic                 bad_out_q;

	logic [CMP_W-1:0]     prime_ext;
	logic [CMP_W-1:0]     n_ext;
	logic [DW-1:0]        div_p;
	logic [DW-1:0]        quo_nxt [LN];
	logic [DW-1:0]        rem_nxt [LN];
	logic [DW:0]          trial   [LN];
	logic                 ge      [LN];
	logic [EW-1:0]        factor;
	logic [WIDE_W-1:0]    wide;
	logic                 out_free;

	assign prime_ext = CMP_W'(prime_q);
	assign n_ext     = CMP_W'(n_q);
	// the divisor is only used once the prime is known not to exceed n
	assign div_p     = DW'(prime_ext);
	assign factor    = exp_q + EW'(1);
	assign wide      = WIDE_W'(prod_q) * WIDE_W'(factor);
	assign out_free  = !valid_q || rsp.ready;
	assign pop       = (state_q == S_IDLE) && head.avail;

	// one restoring-division step on each lane
	always_comb begin
		for (int l = 0; l < LN; l++) begin
			trial[l]   = {rem_q[l], quo_q[l][DW-1]};
			ge[l]      = (trial[l] >= {1'b0, div_p});
			rem_nxt[l] = ge[l] ? DW'(trial[l] - {1'b0, div_p}) : DW'(trial[l]);
			quo_nxt[l] = {quo_q[l][DW-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.avail) begin
						idx_q   <= '0;
						state_q <= head.job.bad ? S_DONE : S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= (prime_ext > n_ext) ? S_DONE : S_LEVEL;
				end
				S_LEVEL: begin
					step_q  <= '0;
					state_q <= (quo_q[0] < div_p) ? S_MULT : S_DIV;
				end
				S_DIV: begin
					if (step_q == STEP_W'(DW - 1)) begin
						state_q <= S_ACC;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_ACC: begin
					state_q <= S_LEVEL;
				end
				S_MULT: begin
					if (idx_q == IDX_W'(NUM_PRIMES - 1)) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_FETCH;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (head.avail) begin
					n_q    <= head.job.total_n;
					k_q    <= head.job.chosen_k;
					rest_q <= head.job.rest;
					bad_q  <= head.job.bad;
					prod_q <= head.job.bad ? '0 : CW'(1);
					ovf_q  <= 1'b0;
				end
			end
			S_FETCH: begin
				prime_q <= PRIME_LIST[idx_q][PRIME_W-1:0];
			end
			S_CHECK: begin
				// reload the lanes with n, k and n - k for the new prime
				quo_q[0] <= n_q;
				quo_q[1] <= k_q;
				quo_q[2] <= rest_q;
				exp_q    <= '0;
			end
			S_LEVEL: begin
				for (int l = 0; l < LN; l++) begin
					rem_q[l] <= '0;
				end
			end
			S_DIV: begin
				for (int l = 0; l < LN; l++) begin
					quo_q[l] <= quo_nxt[l];
					rem_q[l] <= rem_nxt[l];
				end
			end
			S_ACC: begin
				// each level adds the carry, if any, of k + (n - k) in base p
				exp_q <= exp_q + EW'(quo_q[0] - quo_q[1] - quo_q[2]);
			end
			S_MULT: begin
				if (!ovf_q) begin
					if (|wide[WIDE_W-1:CW]) begin
						ovf_q  <= 1'b1;
						prod_q <= '1;
					end else begin
						prod_q <= wide[CW-1:0];
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					count_out_q <= prod_q;
					ovf_out_q   <= ovf_q;
					bad_out_q   <= bad_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid         = valid_q;
	assign rsp.divisor_count = count_out_q;
	assign rsp.overflow      = ovf_out_q;
	assign rsp.bad_input     = bad_out_q;

endmodule

`default_nettype wire

### sv/binomial_divisor_count.sv
// ----------------------------------------------------------------------------
// binomial_divisor_count
// Number of divisors of C(n,k) from Legendre exponents over a prime list.
// ----------------------------------------------------------------------------
// Each request word (total_n, chosen_k) yields one response word with the
// divisor count of C(n,k), saturated at all ones with overflow set, or zero
// with bad_input set when k > n. The back end takes a word from the queue;
// a bad word goes straight to posting its response. Otherwise, for every
// prime p <= n, it fetches p, checks it against n, divides out the L(p)
// base-p digits of n (L(p) = floor(log_p n)), one division level per digit,
// and multiplies in the factor; when the list holds a prime above n, it
// fetches and rejects that prime too before posting the response. The back
// end has a single three-lane restoring divider, which produces one
// quotient bit per cycle for n, k and n - k at once. The front end and a
// two-word queue keep accepting requests while the back end works, until
// the queue fills, and a response register lets the back end start the
// next word while a finished one waits downstream.
// MAX_N bounds the primes considered; the list is built at elaboration.
`default_nettype none

module binomial_divisor_count #(
	parameter int unsigned MAX_N = bdc_pkg::MAX_N_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	bdc_req_if.sink    req,
	bdc_rsp_if.source  rsp
);

	bdc_pkg::push_t  push;
	bdc_pkg::head_t  head;
	logic            full;
	logic            pop;

	// classify incoming words
	bdc_front u_front (
		.req  (req),
		.full (full),
		.push (push)
	);

	// hold classified words until the back end is free
	bdc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full)
	);

	// factor, multiply and register the response
	bdc_back #(
		.MAX_N (MAX_N)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

### sv/bdc_checker.sv
// ----------------------------------------------------------------------------
// bdc_checker
// Port-level checks on the response channel of the block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binomial_divisor_count_assert.svh"

module bdc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [bdc_pkg::COUNT_W-1:0]  divisor_count,
	input logic                         overflow,
	input logic                         bad_input
);

	`BDC_ASSERT_IMPLY(a_bad_zero, clk, arst_n, rsp_valid && bad_input, (divisor_count == '0) && !overflow)
	`BDC_ASSERT_IMPLY(a_ovf_sat, clk, arst_n, rsp_valid && overflow, &divisor_count)
	`BDC_ASSERT_IMPLY(a_good_nonzero, clk, arst_n, rsp_valid && !bad_input, divisor_count != '0)
	`BDC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(divisor_count) && $stable(overflow) && $stable(bad_input))

endmodule

bind binomial_divisor_count bdc_checker u_bdc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.divisor_count (rsp.divisor_count),
	.overflow      (rsp.overflow),
	.bad_input     (rsp.bad_input)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binomial_divisor_count: request words (n, k) go in,
// and each response word is checked against a Legendre-exponent prediction.
// ----------------------------------------------------------------------------
// A queue of pending (n, k) pairs feeds a clocked driver on the request
// channel. The driver predicts each accepted word and stores the result. A
// clocked monitor on the response channel checks every response against the
// oldest stored result. The run has a directed set, then a back-pressure
// burst, then four random phases with different sender and receiver idling.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int unsigned PRIME_BOUND   = bdc_pkg::MAX_N_DEFAULT;
	localparam int unsigned CNT_W         = bdc_pkg::COUNT_W;
	localparam int          RESET_CYCLES  = 6;
	localparam int          HOLD_CYCLES   = 400;
	// Let stragglers from the slowest words (n = 511) show up.
	localparam int          DRAIN_CYCLES  = 2500;
	// The limit is sized for the slowest legal run of about 1000 words.
	localparam int          LIMIT_CYCLES  = 12_000_000;
	localparam int          PHASE_WORDS   = 250;
	localparam int          REPORT_MAX    = 10;

	typedef struct {
		bdc_pkg::arg_t n;
		bdc_pkg::arg_t k;
	} nk_pair_t;

	typedef struct {
		logic [CNT_W-1:0] count;
		logic             overflow;
		logic             bad;
	} count_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bdc_req_if req_ch();
	bdc_rsp_if rsp_ch();

	binomial_divisor_count #(
		.MAX_N (PRIME_BOUND)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Pairs waiting to be offered, and counts due back, oldest first.
	nk_pair_t    pairs_to_send[$];
	count_word_t counts_due[$];

	bit prime_flag [0:PRIME_BOUND];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_req      = 1'b0;
	bit hold_taken    = 1'b0;
	int hold_left     = 0;

	int cycle_count   = 0;
	int words_sent    = 0;
	int words_checked = 0;
	int bad_seen      = 0;
	int ovf_seen      = 0;
	int mismatches    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Exponent of prime p in m!, by Legendre's formula.
	function automatic int unsigned factorial_exponent(input int unsigned m,
			input int unsigned p);
		int unsigned sum;
		int unsigned pw;
		sum = 0;
		pw  = p;
		while (pw <= m) begin
			sum += m / pw;
			pw  *= p;
		end
		return sum;
	endfunction

	// Divisor count of C(n,k): product of (exponent + 1) over the primes,
	// saturating to all ones once the product no longer fits.
	function automatic count_word_t divisors_of_binomial(input bdc_pkg::arg_t n,
			input bdc_pkg::arg_t k);
		count_word_t      res;
		logic [CNT_W-1:0] fac;
		int unsigned      p;
		res.count    = 1;
		res.overflow = 1'b0;
		res.bad      = 1'b0;
		if (k > n) begin
			res.count = '0;
			res.bad   = 1'b1;
			return res;
		end
		for (p = 2; p <= PRIME_BOUND; p++) begin
			if (prime_flag[p] && !res.overflow) begin
				fac = CNT_W'(factorial_exponent(n, p) - factorial_exponent(k, p)
					- factorial_exponent(n - k, p)) + 1;
				if (res.count > {CNT_W{1'b1}} / fac) begin
					res.overflow = 1'b1;
					res.count    = '1;
				end else begin
					res.count = res.count * fac;
				end
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic queue_pair(input int unsigned n, input int unsigned k);
		nk_pair_t pr;
		pr.n = bdc_pkg::arg_t'(n);
		pr.k = bdc_pkg::arg_t'(k);
		pairs_to_send.insert(pairs_to_send.size(), pr);
	endtask

	// Most words use small n to keep the divider busy only briefly; a few
	// span the whole 9-bit range. About one in ten has k > n.
	function automatic nk_pair_t random_pair();
		nk_pair_t    pr;
		int unsigned n;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 55) begin
			n = $urandom_range(63);
		end else if (sel < 85) begin
			n = $urandom_range(255);
		end else begin
			n = $urandom_range(511);
		end
		sel = $urandom_range(99);
		pr.n = bdc_pkg::arg_t'(n);
		if (sel < 10 && n < 511) begin
			pr.k = bdc_pkg::arg_t'($urandom_range(511, n + 1));
		end else if (sel < 15) begin
			pr.k = '0;
		end else if (sel < 20) begin
			pr.k = bdc_pkg::arg_t'(n);
		end else begin
			pr.k = bdc_pkg::arg_t'($urandom_range(n));
		end
		return pr;
	endfunction

	task automatic wait_for_idle();
		while (pairs_to_send.size() != 0 || counts_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver: present the head of the pair queue, predict it once
	// it is taken, and insert sender idle cycles between words.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_request
		logic took;
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.total_n  <= '0;
			req_ch.chosen_k <= '0;
		end else begin
			took = req_ch.valid && req_ch.ready;
			if (took) begin
				counts_due.insert(counts_due.size(),
					divisors_of_binomial(req_ch.total_n, req_ch.chosen_k));
				void'(pairs_to_send.pop_front());
				words_sent++;
			end
			// Hold the current word until it is taken; otherwise pick the next.
			if (!req_ch.valid || took) begin
				if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_ch.valid    <= 1'b1;
					req_ch.total_n  <= pairs_to_send[0].n;
					req_ch.chosen_k <= pairs_to_send[0].k;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Response ready: random stalls, plus one long hold-off on request so
	// the block fills up and pushes back on the request side.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_response_ready
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Response checker
	// ------------------------------------------------------------------
	task automatic note_mismatch(input string what, input count_word_t want);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("[%0t] %s: got count=%0d ovf=%b bad=%b, want count=%0d ovf=%b bad=%b",
				$time, what, rsp_ch.divisor_count, rsp_ch.overflow, rsp_ch.bad_input,
				want.count, want.overflow, want.bad);
		end
	endtask

	always @(posedge clk) begin : check_response
		count_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (counts_due.size() == 0) begin
				want = '{count: '0, overflow: 1'b0, bad: 1'b0};
				note_mismatch("response with nothing outstanding", want);
			end else begin
				want = counts_due.pop_front();
				words_checked++;
				if (want.bad) begin
					bad_seen++;
				end
				if (want.overflow) begin
					ovf_seen++;
				end
				if (rsp_ch.divisor_count !== want.count || rsp_ch.overflow !== want.overflow
						|| rsp_ch.bad_input !== want.bad) begin
					note_mismatch("response mismatch", want);
				end
			end
		end
	end

	// Watchdog: a stuck handshake ends the run here.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("binomial_divisor_count test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : run_test
		int unsigned i;
		int unsigned j;
		int          ph;
		int          send_pcts [4];
		int          stall_pcts [4];

		send_pcts  = '{0, 66, 0, 31};
		stall_pcts = '{0, 0, 66, 31};

		// Own sieve of the primes up to the bound.
		for (i = 0; i <= PRIME_BOUND; i++) begin
			prime_flag[i] = (i >= 2);
		end
		for (i = 2; i * i <= PRIME_BOUND; i++) begin
			if (prime_flag[i]) begin
				for (j = i * i; j <= PRIME_BOUND; j += i) begin
					prime_flag[j] = 1'b0;
				end
			end
		end

		// Assert reset from time zero, release on a rising edge.
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: trivial k = 0 and k = n, k > n, extremes of both fields,
		// central coefficients of large n that may saturate.
		queue_pair(0, 0);
		queue_pair(1, 0);
		queue_pair(1, 1);
		queue_pair(2, 1);
		queue_pair(2, 2);
		queue_pair(3, 1);
		queue_pair(0, 1);
		queue_pair(0, 511);
		queue_pair(510, 511);
		queue_pair(1, 2);
		queue_pair(511, 0);
		queue_pair(511, 511);
		queue_pair(511, 1);
		queue_pair(511, 255);
		queue_pair(511, 256);
		queue_pair(510, 255);
		queue_pair(508, 254);
		queue_pair(500, 250);
		queue_pair(480, 240);
		queue_pair(256, 128);
		queue_pair(256, 255);
		queue_pair(341, 170);
		queue_pair(128, 64);
		queue_pair(100, 50);
		wait_for_idle();

		// Back-pressure: stop taking responses for a long stretch while a
		// burst of quick words keeps arriving, so the request side stalls.
		hold_req = 1'b1;
		for (i = 0; i < 12; i++) begin
			queue_pair($urandom_range(15), $urandom_range(15));
		end
		wait_for_idle();

		// Random phases: no idling, sender idle, receiver stalling, both.
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pcts[ph];
			stall_pct     = stall_pcts[ph];
			for (i = 0; i < PHASE_WORDS; i++) begin
				pairs_to_send.insert(pairs_to_send.size(), random_pair());
			end
			wait_for_idle();
		end
		send_idle_pct = 0;
		stall_pct     = 0;

		// Let any stray response surface before judging.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d of %0d words (%0d with k > n, %0d saturated) in %0d cycles.",
			words_checked, words_sent, bad_seen, ovf_seen, cycle_count);
		$display("Phases: directed, long receiver hold-off, then four idling mixes; %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("binomial_divisor_count test passed");
		end else begin
			$display("binomial_divisor_count test failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/bdc_pkg.sv
sv/bdc_if.sv
sv/bdc_queue.sv
sv/bdc_front.sv
sv/bdc_back.sv
sv/binomial_divisor_count.sv
sv/bdc_checker.sv
dv/tb_top.sv
